### design/lpc_pkg.sv
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types and constants for the LED pattern controller.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int unsigned NUM_CHANNELS_DEFAULT = 3;
  localparam int unsigned MAX_CHANNELS         = 8;

  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PERIOD_W  = 16;
  localparam int unsigned PATTERN_W = 3;
  localparam int unsigned CHANNEL_W = 2;
  localparam int unsigned LED_NUM   = 3;

  localparam logic [PERIOD_W-1:0] PULSE_ON_RESET = 16'd60;

  localparam logic [PATTERN_W-1:0] PAT_OFF        = 3'd0;
  localparam logic [PATTERN_W-1:0] PAT_SOLID      = 3'd1;
  localparam logic [PATTERN_W-1:0] PAT_BLINK_SLOW = 3'd2;
  localparam logic [PATTERN_W-1:0] PAT_BLINK_FAST = 3'd3;
  localparam logic [PATTERN_W-1:0] PAT_PULSE      = 3'd4;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  // Per-channel update command, shared by all channel slices
  typedef struct packed {
    logic                 set;
    logic                 tick;
    logic [TIME_W-1:0]    now;
    logic [PATTERN_W-1:0] pattern;
    logic [PERIOD_W-1:0]  period;
    logic [PERIOD_W-1:0]  pulse_on;
  } lpc_cmd_t;

endpackage

### design/lpc_item_if.sv
// ----------------------------------------------------------------------------
// lpc_item_if
// Input item channel: valid/ready plus one item payload.
// ----------------------------------------------------------------------------
interface lpc_item_if
  import lpc_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic [TIME_W-1:0]    now_ms;
  logic [CHANNEL_W-1:0] channel;
  logic [PATTERN_W-1:0] pattern;
  logic [PERIOD_W-1:0]  period_ms;
  logic                 red_busy;
  logic                 blue_busy;

  modport source (output valid, kind, now_ms, channel, pattern, period_ms, red_busy,
                  blue_busy, input ready);
  modport sink (input valid, kind, now_ms, channel, pattern, period_ms, red_busy,
                blue_busy, output ready);
endinterface

### design/lpc_result_if.sv
// ----------------------------------------------------------------------------
// lpc_result_if
// Result channel: valid/ready plus the three LED levels.
// ----------------------------------------------------------------------------
interface lpc_result_if;
  logic valid;
  logic ready;
  logic led_red;
  logic led_green;
  logic led_blue;

  modport source (output valid, led_red, led_green, led_blue, input ready);
  modport sink (input valid, led_red, led_green, led_blue, output ready);
endinterface

### design/lpc_cfg_if.sv
// ----------------------------------------------------------------------------
// lpc_cfg_if
// Configuration write channel for the pulse on-time register.
// ----------------------------------------------------------------------------
interface lpc_cfg_if
  import lpc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [PERIOD_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### design/lpc_channel.sv
// ----------------------------------------------------------------------------
// lpc_channel
// State and update logic of one LED channel (pattern, period, phase, timer).
// ----------------------------------------------------------------------------
module lpc_channel
  import lpc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  lpc_cmd_t cmd,
  input  logic     busy,
  output logic     phase_next
);

  logic [PATTERN_W-1:0] pattern, pattern_next;
  logic [PERIOD_W-1:0]  period, period_next;
  logic                 phase;
  logic [TIME_W-1:0]    last_change, last_change_next;
  logic [TIME_W-1:0]    elapsed;
  logic                 period_done;
  logic                 pulse_done;

  assign elapsed     = cmd.now - last_change;
  assign period_done = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, period};
  assign pulse_done  = elapsed >= {{(TIME_W-PERIOD_W){1'b0}}, cmd.pulse_on};

  always_comb begin
    pattern_next     = pattern;
    period_next      = period;
    phase_next       = phase;
    last_change_next = last_change;
    if (cmd.set) begin
      pattern_next     = cmd.pattern;
      period_next      = cmd.period;
      last_change_next = cmd.now;
      phase_next       = (cmd.pattern == PAT_SOLID);
    end else if (cmd.tick && !busy) begin
      if (pattern == PAT_BLINK_SLOW || pattern == PAT_BLINK_FAST) begin
        if (period_done) begin
          phase_next       = ~phase;
          last_change_next = cmd.now;
        end
      end else if (pattern == PAT_PULSE) begin
        // lit: wait out the on time; dark: wait out the period
        if (phase ? pulse_done : period_done) begin
          phase_next       = ~phase;
          last_change_next = cmd.now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= PAT_OFF;
      period      <= '0;
      phase       <= 1'b0;
      last_change <= '0;
    end else begin
      pattern     <= pattern_next;
      period      <= period_next;
      phase       <= phase_next;
      last_change <= last_change_next;
    end
  end

endmodule

### design/led_pattern_controller_unit.sv
// ----------------------------------------------------------------------------
// led_pattern_controller_unit
// LED pattern engine: per-channel blink/pulse timers driven by time ticks.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless stalled. An accepted item sits in the
// input register, the channel slices update in parallel from it (one 32-bit
// subtract and two compares each), and the updated LED levels land in the
// result register at the same edge. The result register lets a new item in
// while a finished result waits on the output; with both registers full the
// input stalls.
// The pulse on-time register may be written at any cycle the block is idle.
module led_pattern_controller_unit
  import lpc_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  lpc_item_if.sink     items,
  lpc_result_if.source results,
  lpc_cfg_if.sink      cfg
);

  logic [PERIOD_W-1:0] pulse_on;

  // input register
  logic                 in_vld;
  logic                 in_kind;
  logic [TIME_W-1:0]    in_now;
  logic [CHANNEL_W-1:0] in_channel;
  logic [PATTERN_W-1:0] in_pattern;
  logic [PERIOD_W-1:0]  in_period;
  logic                 in_red_busy;
  logic                 in_blue_busy;

  logic                    out_vld;
  logic                    process;
  logic [NUM_CHANNELS-1:0] phase;
  logic [LED_NUM-1:0]      led;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_on <= PULSE_ON_RESET;
    end else if (cfg.valid) begin
      pulse_on <= cfg.data;
    end
  end

  assign process     = in_vld && (!out_vld || results.ready);
  assign items.ready = !in_vld || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (items.ready) begin
      in_vld <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      in_kind      <= items.kind;
      in_now       <= items.now_ms;
      in_channel   <= items.channel;
      in_pattern   <= items.pattern;
      in_period    <= items.period_ms;
      in_red_busy  <= items.red_busy;
      in_blue_busy <= items.blue_busy;
    end
  end

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    lpc_cmd_t cmd;
    logic     busy;

    always_comb begin
      cmd.set      = process && (in_kind == KIND_SET) && (int'(in_channel) == i);
      cmd.tick     = process && (in_kind == KIND_TICK);
      cmd.now      = in_now;
      cmd.pattern  = in_pattern;
      cmd.period   = in_period;
      cmd.pulse_on = pulse_on;
    end

    assign busy = ((i == 0) && in_red_busy) || ((i == 2) && in_blue_busy);

    lpc_channel u_channel (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .busy       (busy),
      .phase_next (phase[i])
    );
  end

  // levels after the update; missing channels read dark
  for (genvar j = 0; j < LED_NUM; j++) begin : g_led
    if (j < NUM_CHANNELS) begin : g_present
      assign led[j] = phase[j];
    end else begin : g_absent
      assign led[j] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (process) begin
      out_vld <= 1'b1;
    end else if (results.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      results.led_red   <= led[0];
      results.led_green <= led[1];
      results.led_blue  <= led[2];
    end
  end

  assign results.valid = out_vld;

endmodule
